// ===== sv/mm4t_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mm4t_pkg
// Shared sizes, types and helper functions for the transposed matrix product.
// ---------------------------------------------------------------------------
package mm4t_pkg;

   localparam int MATRIX_DIM = 4;
   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
   localparam int IDX_BITS   = $clog2(CELLS);
   localparam int K_BITS     = $clog2(MATRIX_DIM);
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int ACC_BITS   = PROD_BITS + K_BITS;

   // Control that travels with one term of a dot product.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // Input word (32 bits) to a stored word of WORD_BITS bits.
   function automatic logic signed [WORD_BITS-1:0] to_word(input logic signed [31:0] v);
      logic signed [63:0] ext;
      ext = 64'(v);
      return ext[WORD_BITS-1:0];
   endfunction

   // Stored-width value back to the 32-bit result field.
   function automatic logic signed [31:0] to_port(input logic signed [WORD_BITS-1:0] v);
      logic signed [63:0] ext;
      ext = 64'(v);
      return ext[31:0];
   endfunction

   // Drop the fraction bits of a full sum and clamp it to the word range.
   function automatic logic signed [WORD_BITS-1:0] scale_sat(
      input logic signed [ACC_BITS-1:0] acc);
      logic signed [ACC_BITS-1:0] s;
      logic                       fits;
      s    = acc >>> FRAC_BITS;
      fits = (&s[ACC_BITS-1:WORD_BITS-1]) | ~(|s[ACC_BITS-1:WORD_BITS-1]);
      if (fits) begin
         return s[WORD_BITS-1:0];
      end else if (s[ACC_BITS-1]) begin
         return {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(WORD_BITS-1){1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

// ===== sv/mm4t_store.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mm4t_store
// Element memories for both matrices: one write port, one registered read
// port per matrix.
// ---------------------------------------------------------------------------
module mm4t_store (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic                                  wr_sel,
   input  wire logic [mm4t_pkg::IDX_BITS-1:0]         wr_addr,
   input  wire logic signed [mm4t_pkg::WORD_BITS-1:0] wr_data,
   input  wire logic [mm4t_pkg::IDX_BITS-1:0]         a_addr,
   input  wire logic [mm4t_pkg::IDX_BITS-1:0]         b_addr,
   output logic signed [mm4t_pkg::WORD_BITS-1:0]      a_rd_data,
   output logic signed [mm4t_pkg::WORD_BITS-1:0]      b_rd_data
);

   logic signed [mm4t_pkg::WORD_BITS-1:0] camera_mem [mm4t_pkg::CELLS];
   logic signed [mm4t_pkg::WORD_BITS-1:0] object_mem [mm4t_pkg::CELLS];
   logic signed [mm4t_pkg::WORD_BITS-1:0] a_rd_ff;
   logic signed [mm4t_pkg::WORD_BITS-1:0] b_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_sel) begin
         camera_mem[wr_addr] <= wr_data;
      end
      if (wr_en && wr_sel) begin
         object_mem[wr_addr] <= wr_data;
      end
      a_rd_ff <= camera_mem[a_addr];
      b_rd_ff <= object_mem[b_addr];
   end

   assign a_rd_data = a_rd_ff;
   assign b_rd_data = b_rd_ff;

endmodule
`default_nettype wire

// ===== sv/mm4t_mac.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mm4t_mac
// Shared multiply-accumulate unit: a registered product stage followed by a
// full-precision accumulator that restarts on the first term.
// ---------------------------------------------------------------------------
module mm4t_mac (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire mm4t_pkg::mac_ctl_type                 ctl,
   input  wire logic signed [mm4t_pkg::WORD_BITS-1:0] a_data,
   input  wire logic signed [mm4t_pkg::WORD_BITS-1:0] b_data,
   output logic signed [mm4t_pkg::ACC_BITS-1:0]       acc,
   output logic                                       done
);

   logic signed [mm4t_pkg::PROD_BITS-1:0] product_in;
   logic signed [mm4t_pkg::PROD_BITS-1:0] product_ff;
   mm4t_pkg::mac_ctl_type                 prod_ctl_ff;
   logic signed [mm4t_pkg::ACC_BITS-1:0]  product_ext;
   logic signed [mm4t_pkg::ACC_BITS-1:0]  acc_in;
   logic signed [mm4t_pkg::ACC_BITS-1:0]  acc_ff;
   logic                                  done_ff;

   assign product_in  = mm4t_pkg::PROD_BITS'(a_data) * mm4t_pkg::PROD_BITS'(b_data);
   assign product_ext = {{mm4t_pkg::K_BITS{product_ff[mm4t_pkg::PROD_BITS-1]}}, product_ff};
   assign acc_in      = prod_ctl_ff.first ? product_ext : acc_ff + product_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         done_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= ctl;
         done_ff     <= prod_ctl_ff.valid && prod_ctl_ff.last;
      end
      product_ff <= product_in;
      if (prod_ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

// ===== sv/matrix4x4_multiply_transposed.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// matrix4x4_multiply_transposed
// Loads two 4x4 Q16.16 matrices and emits their product, stored transposed.
// ---------------------------------------------------------------------------
// The req channel carries one matrix element per word: which matrix, the
// row-major index and the value. It takes one word per cycle in ST_IDLE. A word
// marked last is stored and then starts the product run; req_ready stays low
// until the sixteenth result has been loaded into the output register.
// Each result is a four-term dot product through one shared multiplier and
// accumulator: four memory reads issued on successive cycles, a read stage,
// a product stage and an accumulate stage, then the emit state loads the
// output register once it is free; the next result is not issued before
// that load. Results leave on the rsp channel in ascending result_index
// order, with last_result set on the sixteenth. A stalled receiver holds
// the run at its next result; nothing is dropped.
// Reset clears the sequencer and the output valid. The element memories are
// not cleared; elements must be written before a product reads them.
// ---------------------------------------------------------------------------
module matrix4x4_multiply_transposed (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_which_matrix,
   input  wire logic [3:0]         req_element_index,
   input  wire logic signed [31:0] req_element_value,
   input  wire logic               req_last_element,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [3:0]              rsp_result_index,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_last_result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                              state_ff;
   logic [mm4t_pkg::K_BITS-1:0]            k_ff;
   logic [mm4t_pkg::K_BITS-1:0]            row_ff;
   logic [mm4t_pkg::K_BITS-1:0]            col_ff;
   logic [mm4t_pkg::IDX_BITS-1:0]          n_ff;
   mm4t_pkg::mac_ctl_type                  iss_ctl_in;
   mm4t_pkg::mac_ctl_type                  iss_ctl_ff;
   logic                                   rsp_valid_ff;
   logic [3:0]                             rsp_index_ff;
   logic signed [31:0]                     rsp_value_ff;
   logic                                   rsp_last_ff;

   logic                                   req_fire;
   logic                                   wr_en;
   logic [mm4t_pkg::IDX_BITS-1:0]          wr_addr;
   logic signed [mm4t_pkg::WORD_BITS-1:0]  wr_data;
   logic [mm4t_pkg::IDX_BITS-1:0]          a_addr;
   logic [mm4t_pkg::IDX_BITS-1:0]          b_addr;
   logic signed [mm4t_pkg::WORD_BITS-1:0]  a_rd_data;
   logic signed [mm4t_pkg::WORD_BITS-1:0]  b_rd_data;
   logic signed [mm4t_pkg::ACC_BITS-1:0]   mac_acc;
   logic                                   mac_done;
   logic                                   slot_free;
   logic                                   k_end;
   logic                                   col_end;
   logic                                   run_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && (int'(req_element_index) < mm4t_pkg::CELLS);
   assign wr_addr   = mm4t_pkg::IDX_BITS'(req_element_index);
   assign wr_data   = mm4t_pkg::to_word(req_element_value);

   // Term k of result (row, col) pairs A[row + n*k] with B[n*col + k].
   assign a_addr = mm4t_pkg::IDX_BITS'(int'(row_ff) + mm4t_pkg::MATRIX_DIM * int'(k_ff));
   assign b_addr = mm4t_pkg::IDX_BITS'(mm4t_pkg::MATRIX_DIM * int'(col_ff) + int'(k_ff));

   assign k_end     = (k_ff == mm4t_pkg::K_BITS'(mm4t_pkg::MATRIX_DIM - 1));
   assign col_end   = (col_ff == mm4t_pkg::K_BITS'(mm4t_pkg::MATRIX_DIM - 1));
   assign run_end   = (n_ff == mm4t_pkg::IDX_BITS'(mm4t_pkg::CELLS - 1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      iss_ctl_in.valid = (state_ff == ST_ISSUE);
      iss_ctl_in.first = (k_ff == '0);
      iss_ctl_in.last  = k_end;
   end

   mm4t_store u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_sel    (req_which_matrix),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .a_addr    (a_addr),
      .b_addr    (b_addr),
      .a_rd_data (a_rd_data),
      .b_rd_data (b_rd_data)
   );

   mm4t_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iss_ctl_ff),
      .a_data (a_rd_data),
      .b_data (b_rd_data),
      .acc    (mac_acc),
      .done   (mac_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         n_ff         <= '0;
         iss_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         iss_ctl_ff <= iss_ctl_in;
         if (state_ff == ST_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_last_element) begin
                  k_ff     <= '0;
                  row_ff   <= '0;
                  col_ff   <= '0;
                  n_ff     <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (k_end) begin
                  k_ff     <= '0;
                  state_ff <= ST_DRAIN;
               end else begin
                  k_ff <= k_ff + mm4t_pkg::K_BITS'(1);
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // The accumulator holds its sum until the next result is issued.
               if (slot_free) begin
                  rsp_index_ff <= 4'(n_ff);
                  rsp_value_ff <= mm4t_pkg::to_port(mm4t_pkg::scale_sat(mac_acc));
                  rsp_last_ff  <= run_end;
                  n_ff         <= n_ff + mm4t_pkg::IDX_BITS'(1);
                  if (col_end) begin
                     col_ff <= '0;
                     row_ff <= row_ff + mm4t_pkg::K_BITS'(1);
                  end else begin
                     col_ff <= col_ff + mm4t_pkg::K_BITS'(1);
                  end
                  state_ff <= run_end ? ST_IDLE : ST_ISSUE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_last_result  = rsp_last_ff;

`ifndef SYNTHESIS
   // The accumulator only finishes a sum while the sequencer waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("dot product finished outside the drain state");

   // The final result of a run returns the block to accepting words.
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && run_end) |=> (state_ff == ST_IDLE && rsp_last_ff))
      else $error("run did not end after its last result");

   // A result is loaded only into a free output slot.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ready) |=> $stable(rsp_value_ff))
      else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_matrix4x4_multiply_transposed.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tb_matrix4x4_multiply_transposed
// Self-checking bench for the transposed 4x4 Q16.16 matrix product.
// ---------------------------------------------------------------------------
// Loads both matrices completely with boundary values, then fires products
// from directed single-element updates and from random load sequences. An
// internal copy of both matrices predicts the sixteen results of every run,
// and each word on the rsp channel is compared against the oldest prediction.
// Sender gaps and receiver stalls change over three phases of the run.
// ---------------------------------------------------------------------------
module tb_matrix4x4_multiply_transposed;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit LOAD_CAMERA = 1'b0;
   localparam bit LOAD_OBJECT = 1'b1;
   localparam int RANDOM_WORDS = 92;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [3:0]         index;
      logic signed [31:0] value;
      logic               last;
   } product_word_type;

   // Keeps both matrices and the products still owed by the block.
   class product_tracker_type;
      logic signed [mm4t_pkg::WORD_BITS-1:0] camera [mm4t_pkg::CELLS];
      logic signed [mm4t_pkg::WORD_BITS-1:0] object [mm4t_pkg::CELLS];
      product_word_type                      expected [$];
      int                                    fails = 0;

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fails++;
      endtask

      function int pending();
         return expected.size();
      endfunction

      // Full-precision dot product, floor shift, then clamp to the word range.
      function logic signed [31:0] product_entry(int row, int col);
         logic signed [66:0] acc;
         logic signed [66:0] a;
         logic signed [66:0] b;
         logic signed [66:0] hi_lim;
         logic signed [66:0] lo_lim;
         acc = '0;
         hi_lim = (67'sd1 <<< (mm4t_pkg::WORD_BITS - 1)) - 67'sd1;
         lo_lim = -hi_lim - 67'sd1;
         for (int k = 0; k < mm4t_pkg::MATRIX_DIM; k++) begin
            a = camera[row + mm4t_pkg::MATRIX_DIM * k];
            b = object[mm4t_pkg::MATRIX_DIM * col + k];
            acc += a * b;
         end
         acc = acc >>> mm4t_pkg::FRAC_BITS;
         if (acc > hi_lim) begin
            acc = hi_lim;
         end else if (acc < lo_lim) begin
            acc = lo_lim;
         end
         return acc[31:0];
      endfunction

      task load_element(bit which, logic [3:0] idx, logic signed [31:0] value, bit last);
         product_word_type w;
         if (which == LOAD_OBJECT) begin
            object[idx] = value[mm4t_pkg::WORD_BITS-1:0];
         end else begin
            camera[idx] = value[mm4t_pkg::WORD_BITS-1:0];
         end
         if (last) begin
            for (int n = 0; n < mm4t_pkg::CELLS; n++) begin
               w.index = n[3:0];
               w.value = product_entry(n / mm4t_pkg::MATRIX_DIM, n % mm4t_pkg::MATRIX_DIM);
               w.last  = (n == mm4t_pkg::CELLS - 1);
               expected.push_back(w);
            end
         end
      endtask

      task check_product(logic [3:0] idx, logic signed [31:0] value, logic last);
         product_word_type want;
         if (expected.size() == 0) begin
            report($sformatf("unexpected result index %0d value %0d", idx, value));
            return;
         end
         want = expected.pop_front();
         if (idx !== want.index) begin
            report($sformatf("result_index got %0d want %0d", idx, want.index));
         end
         if (value !== want.value) begin
            report($sformatf("result_value at index %0d got %0d want %0d",
                             want.index, value, want.value));
         end
         if (last !== want.last) begin
            report($sformatf("last_result at index %0d got %b want %b",
                             want.index, last, want.last));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_which_matrix = LOAD_CAMERA;
   logic [3:0]         req_element_index = '0;
   logic signed [31:0] req_element_value = '0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_result_index;
   logic signed [31:0] rsp_result_value;
   logic               rsp_last_result;

   product_tracker_type tracker = new();
   int send_gap_pct = 10;
   int recv_stall_pct = 73;
   int quiet_cycles = 0;

   matrix4x4_multiply_transposed uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_which_matrix  (req_which_matrix),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_index  (rsp_result_index),
      .rsp_result_value  (rsp_result_value),
      .rsp_last_result   (rsp_last_result)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_product(rsp_result_index, rsp_result_value, rsp_last_result);
      end
   end

   // Any accepted word on either channel counts as progress.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("matrix4x4_multiply_transposed test failed");
         $finish;
      end
   end

   function automatic logic [31:0] edge_value(int i);
      case (i % 8)
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0001_0000;
         5: return 32'hffff_0000;
         6: return 32'h0000_0001;
         default: return 32'h0000_ffff;
      endcase
   endfunction

   function automatic logic [31:0] random_element();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return $urandom_range(32'h3ffff) - 32'h20000;
         7: return edge_value($urandom_range(7));
         default: return ($urandom_range(15) - 8) << mm4t_pkg::FRAC_BITS;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(bit which, logic [3:0] idx, logic [31:0] value, bit last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_which_matrix  <= which;
      req_element_index <= idx;
      req_element_value <= value;
      req_last_element  <= last;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      tracker.load_element(which, idx, value, last);
      @(negedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every element is written before the first product reads it.
      for (int i = 0; i < mm4t_pkg::CELLS; i++) begin
         send_word(LOAD_CAMERA, i[3:0], edge_value(i), 1'b0);
      end
      for (int i = 0; i < mm4t_pkg::CELLS; i++) begin
         send_word(LOAD_OBJECT, i[3:0], edge_value(i + 3), i == mm4t_pkg::CELLS - 1);
      end

      // Single-element updates: the first entry into both clamps, then the last entry.
      send_word(LOAD_CAMERA, 4'd0, 32'h7fff_ffff, 1'b0);
      send_word(LOAD_OBJECT, 4'd0, 32'h7fff_ffff, 1'b1);
      send_word(LOAD_OBJECT, 4'd0, 32'h8000_0000, 1'b1);
      send_word(LOAD_CAMERA, 4'd0, 32'h8000_0000, 1'b1);
      send_word(LOAD_CAMERA, 4'd15, 32'hffff_ffff, 1'b0);
      send_word(LOAD_OBJECT, 4'd15, 32'h0000_0001, 1'b1);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 3) begin
            send_gap_pct   = 73;
            recv_stall_pct = 10;
         end else if (i == 2 * RANDOM_WORDS / 3) begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
         send_word(1'($urandom_range(1)), 4'($urandom_range(15)), random_element(),
                   ($urandom_range(9) == 0) || (i == RANDOM_WORDS - 1));
      end
      req_valid <= 1'b0;

      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.fails == 0) begin
         $display("matrix4x4_multiply_transposed test passed");
      end else begin
         $display("matrix4x4_multiply_transposed test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
